// File: src/nrf_pkg.sv
// Shared types, constants and arithmetic helpers for the Newton root finder.
// No dependencies; imported by every module of the block.
`default_nettype none
package nrf_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_ITERATIONS = 63;
  localparam int XW  = 32;
  localparam int VW  = 48;
  localparam int CW  = 6;
  localparam int TW  = 16;
  localparam int DIV_STEPS = 64;
  localparam int DCW = $clog2(DIV_STEPS + 1);

  localparam logic signed [VW-1:0] MAX48 = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MIN48 = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE   = VW'(1) << FRAC_BITS;

  localparam logic [1:0] SEL_F1 = 2'd0;
  localparam logic [1:0] SEL_F2 = 2'd1;

  localparam logic [1:0] SRC_X  = 2'd0;
  localparam logic [1:0] SRC_X2 = 2'd1;
  localparam logic [1:0] SRC_X3 = 2'd2;

  localparam logic [1:0] REG_FSEL = 2'd0;
  localparam logic [1:0] REG_CNT  = 2'd1;
  localparam logic [1:0] REG_THR  = 2'd2;

  typedef struct packed {
    logic          load_x;
    logic          mul_lo;
    logic          mul_hi;
    logic [1:0]    mul_src;
    logic          terms;
    logic          fold;
    logic          div_start;
    logic          newton;
    logic          emit_rep;
    logic          emit_fin;
    logic [CW-1:0] idx;
    logic          flat;
  } cmd_t;

  typedef struct packed {
    logic flat;
    logic div_done;
  } sts_t;

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? MIN48 : MAX48;
    return s[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] scale(input logic signed [7:0] k,
                                                 input logic signed [VW-1:0] v);
    logic signed [VW+7:0] ve;
    logic signed [VW+7:0] ke;
    logic signed [VW+7:0] p;
    ve = {{8{v[VW-1]}}, v};
    ke = {{VW{k[7]}}, k};
    p  = ve * ke;
    if (p[VW+7:VW-1] == {9{p[VW+7]}}) return p[VW-1:0];
    return p[VW+7] ? MIN48 : MAX48;
  endfunction

endpackage
`default_nettype wire

// File: src/nrf_div.sv
// Restoring divider, one quotient bit per cycle: ({num,frac zeros}) / den.
// Depends on nrf_pkg.
`default_nettype none
module nrf_div import nrf_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [VW-1:0] num_i,
  input  wire logic [VW-1:0] den_i,
  output logic               done_o,
  output logic [DIV_STEPS-1:0] quo_o
);
  logic [DIV_STEPS-1:0] n_q, quo_q;
  logic [VW-1:0]        rem_q, rem_d;
  logic [DCW-1:0]       cnt_q;
  logic                 run_q, done_q;
  logic [VW:0]          r;
  logic                 ge;

  always_comb begin
    r     = {rem_q, n_q[DIV_STEPS-1]};
    ge    = r >= {1'b0, den_i};
    rem_d = ge ? VW'(r - {1'b0, den_i}) : r[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DCW'(DIV_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {num_i, {(DIV_STEPS-VW){1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      n_q   <= n_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_STEPS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// File: src/nrf_dp.sv
// Datapath: x, powers, polynomial terms, Newton update and result registers.
// Depends on nrf_pkg and nrf_div.
`default_nettype none
module nrf_dp import nrf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  input  wire logic signed [XW-1:0] start_point_i,
  input  wire logic [1:0]           fsel_i,
  input  wire logic [TW-1:0]        thr_i,
  output logic                      strobe_o,
  output logic                      kind_o,
  output logic [CW-1:0]             idx_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [VW-1:0]      f_o,
  output logic                      flat_o,
  output logic                      last_o
);
  logic signed [XW-1:0] x_q, x_d;
  logic signed [VW-1:0] p2_q, p3_q, p4_q;
  logic signed [VW-1:0] ft_q [4];
  logic signed [VW-1:0] dt_q [3];
  logic [79:0]          acc_q;

  logic signed [VW-1:0] a, msat, dmag_s;
  logic [VW-1:0]        ua, fmag, dmag;
  logic [XW-1:0]        ux;
  logic [15:0]          chunk;
  logic [63:0]          prod, m;
  logic [79:0]          psum;
  logic                 mneg, ovf;
  logic                 div_done;
  logic [DIV_STEPS-1:0] quo;
  logic [50:0]          qm;
  logic signed [52:0]   qs, nx;
  logic signed [VW-1:0] xe;

  always_comb begin
    case (cmd_i.mul_src)
      SRC_X:   a = {{(VW-XW){x_q[XW-1]}}, x_q};
      SRC_X2:  a = p2_q;
      SRC_X3:  a = p3_q;
      default: a = p3_q;
    endcase
    ua    = a[VW-1] ? VW'(-a) : a;
    ux    = x_q[XW-1] ? XW'(-x_q) : x_q;
    chunk = cmd_i.mul_hi ? ux[31:16] : ux[15:0];
    prod  = {16'b0, ua} * {48'b0, chunk};
    psum  = acc_q + {prod, 16'b0};
    m     = psum[79:16];
    mneg  = a[VW-1] ^ x_q[XW-1];
    ovf   = |m[63:VW-1];
    if (mneg) msat = ovf ? MIN48 : -$signed(m[VW-1:0]);
    else      msat = ovf ? MAX48 : $signed(m[VW-1:0]);
  end

  always_comb begin
    fmag   = ft_q[0][VW-1] ? VW'(-ft_q[0]) : ft_q[0];
    dmag   = dt_q[0][VW-1] ? VW'(-dt_q[0]) : dt_q[0];
    dmag_s = dt_q[0];
    qm     = (quo[63:16] > 48'h2_0000_0000) ? 51'(64'd1 << 40) : quo[50:0];
    qs     = (ft_q[0][VW-1] ^ dt_q[0][VW-1]) ? -$signed({2'b0, qm}) : $signed({2'b0, qm});
    nx     = {{21{x_q[XW-1]}}, x_q} - qs;
    if (nx[52:31] == {22{nx[52]}}) x_d = nx[31:0];
    else x_d = nx[52] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    xe     = {{(VW-XW){x_q[XW-1]}}, x_q};
  end

  assign sts_o.flat     = (dmag_s == '0) || (dmag < {{(VW-TW){1'b0}}, thr_i});
  assign sts_o.div_done = div_done;

  nrf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (fmag),
    .den_i   (dmag),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) x_q <= start_point_i;
    else if (cmd_i.newton) x_q <= x_d;
    if (cmd_i.mul_lo) acc_q <= {16'b0, prod};
    if (cmd_i.mul_hi) begin
      case (cmd_i.mul_src)
        SRC_X:   p2_q <= msat;
        SRC_X2:  p3_q <= msat;
        default: p4_q <= msat;
      endcase
    end
    if (cmd_i.terms) begin
      case (fsel_i)
        SEL_F1: begin
          ft_q[0] <= scale(-8'sd1, p3_q);
          ft_q[1] <= scale(8'sd10, xe);
          ft_q[2] <= 48'(5) <<< FRAC_BITS;
          ft_q[3] <= '0;
          dt_q[0] <= scale(-8'sd3, p2_q);
          dt_q[1] <= 48'(10) <<< FRAC_BITS;
          dt_q[2] <= '0;
        end
        SEL_F2: begin
          ft_q[0] <= scale(8'sd3, p4_q);
          ft_q[1] <= scale(-8'sd5, p2_q);
          ft_q[2] <= scale(8'sd100, xe);
          ft_q[3] <= 48'(10) <<< FRAC_BITS;
          dt_q[0] <= scale(8'sd12, p3_q);
          dt_q[1] <= scale(-8'sd10, xe);
          dt_q[2] <= 48'(100) <<< FRAC_BITS;
        end
        default: begin
          ft_q[0] <= p2_q;
          ft_q[1] <= -(ONE <<< 2);
          ft_q[2] <= '0;
          ft_q[3] <= '0;
          dt_q[0] <= scale(8'sd2, xe);
          dt_q[1] <= '0;
          dt_q[2] <= '0;
        end
      endcase
    end else if (cmd_i.fold) begin
      ft_q[0] <= sat_add(ft_q[0], ft_q[1]);
      ft_q[1] <= ft_q[2];
      ft_q[2] <= ft_q[3];
      ft_q[3] <= '0;
      dt_q[0] <= sat_add(dt_q[0], dt_q[1]);
      dt_q[1] <= dt_q[2];
      dt_q[2] <= '0;
    end
    if (cmd_i.emit_rep || cmd_i.emit_fin) begin
      kind_o <= cmd_i.emit_fin;
      idx_o  <= cmd_i.idx;
      x_o    <= x_q;
      f_o    <= cmd_i.emit_fin ? '0 : ft_q[0];
      flat_o <= cmd_i.emit_fin & cmd_i.flat;
      last_o <= cmd_i.emit_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_o <= 1'b0;
    else strobe_o <= cmd_i.emit_rep | cmd_i.emit_fin;
  end
endmodule
`default_nettype wire

// File: src/nrf_ctrl.sv
// Controller: sequences powers, terms, flat check, division and reports.
// Depends on nrf_pkg.
`default_nettype none
module nrf_ctrl import nrf_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-1:0] count_i,
  input  wire sts_t          sts_i,
  output cmd_t               cmd_o,
  output logic               busy_o
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_M2L = 5'd1,  S_M2H = 5'd2,  S_M3L = 5'd3;
  localparam logic [4:0] S_M3H  = 5'd4,  S_M4L = 5'd5,  S_M4H = 5'd6,  S_TERM = 5'd7;
  localparam logic [4:0] S_F1   = 5'd8,  S_F2  = 5'd9,  S_F3  = 5'd10, S_CHK = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12, S_DIVW = 5'd13, S_NEWT = 5'd14, S_REP = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] done_q, done_d, n_q, n_d;
  logic          rep_q, rep_d, flat_q, flat_d;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    n_d     = n_q;
    rep_d   = rep_q;
    flat_d  = flat_q;
    cmd_o   = '0;
    cmd_o.idx  = done_q;
    cmd_o.flat = flat_q;
    case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.load_x = 1'b1;
        done_d  = '0;
        rep_d   = 1'b0;
        flat_d  = 1'b0;
        n_d     = (count_i > CW'(MAX_ITERATIONS)) ? CW'(MAX_ITERATIONS) : count_i;
        state_d = S_M2L;
      end
      S_M2L: begin cmd_o.mul_lo = 1'b1; cmd_o.mul_src = SRC_X;  state_d = S_M2H; end
      S_M2H: begin cmd_o.mul_hi = 1'b1; cmd_o.mul_src = SRC_X;  state_d = S_M3L; end
      S_M3L: begin cmd_o.mul_lo = 1'b1; cmd_o.mul_src = SRC_X2; state_d = S_M3H; end
      S_M3H: begin cmd_o.mul_hi = 1'b1; cmd_o.mul_src = SRC_X2; state_d = S_M4L; end
      S_M4L: begin cmd_o.mul_lo = 1'b1; cmd_o.mul_src = SRC_X3; state_d = S_M4H; end
      S_M4H: begin cmd_o.mul_hi = 1'b1; cmd_o.mul_src = SRC_X3; state_d = S_TERM; end
      S_TERM: begin cmd_o.terms = 1'b1; state_d = S_F1; end
      S_F1: begin cmd_o.fold = 1'b1; state_d = S_F2; end
      S_F2: begin cmd_o.fold = 1'b1; state_d = S_F3; end
      S_F3: begin cmd_o.fold = 1'b1; state_d = rep_q ? S_REP : S_CHK; end
      S_REP: begin cmd_o.emit_rep = 1'b1; state_d = S_CHK; end
      S_CHK: begin
        if (done_q == n_q) state_d = S_FIN;
        else if (sts_i.flat) begin
          flat_d  = 1'b1;
          state_d = S_FIN;
        end else state_d = S_DIV;
      end
      S_DIV: begin cmd_o.div_start = 1'b1; state_d = S_DIVW; end
      S_DIVW: if (sts_i.div_done) state_d = S_NEWT;
      S_NEWT: begin
        cmd_o.newton = 1'b1;
        done_d  = done_q + 1'b1;
        rep_d   = 1'b1;
        state_d = S_M2L;
      end
      S_FIN: begin cmd_o.emit_fin = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= '0;
      n_q     <= '0;
      rep_q   <= 1'b0;
      flat_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      n_q     <= n_d;
      rep_q   <= rep_d;
      flat_q  <= flat_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
endmodule
`default_nettype wire

// File: src/newton_root_finder.sv
// Newton root finder top level: register port, controller and datapath.
// Depends on nrf_pkg, nrf_ctrl and nrf_dp.
// Each iteration runs polynomial evaluation on a 48x16 multiplier, the 64-step restoring
// divider with its start and hand-back, and the update, report and check.
// One request at a time; reports come out as strobes that cannot be stalled.
// Reset: registers return to f1, five iterations, threshold one; controller idles.
`default_nettype none
module newton_root_finder import nrf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic signed [XW-1:0] start_point_i,
  output logic                      result_strobe_o,
  output logic                      report_kind_o,
  output logic [CW-1:0]             iteration_index_o,
  output logic signed [XW-1:0]      x_value_o,
  output logic signed [VW-1:0]      f_value_o,
  output logic                      stopped_flat_o,
  output logic                      last_o
);
  logic [1:0]    fsel_q;
  logic [CW-1:0] cnt_q;
  logic [TW-1:0] thr_q;
  logic          wr;
  cmd_t          cmd;
  sts_t          sts;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q <= 2'd0;
      cnt_q  <= CW'(5);
      thr_q  <= TW'(1);
    end else if (wr) begin
      case (paddr[3:2])
        REG_FSEL: fsel_q <= pwdata[1:0];
        REG_CNT:  cnt_q  <= pwdata[CW-1:0];
        REG_THR:  thr_q  <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FSEL: prdata = {30'b0, fsel_q};
      REG_CNT:  prdata = {{(32-CW){1'b0}}, cnt_q};
      REG_THR:  prdata = {{(32-TW){1'b0}}, thr_q};
      default:  prdata = '0;
    endcase
  end

  nrf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .count_i (cnt_q),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  nrf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_point_i (start_point_i),
    .fsel_i        (fsel_q),
    .thr_i         (thr_q),
    .strobe_o      (result_strobe_o),
    .kind_o        (report_kind_o),
    .idx_o         (iteration_index_o),
    .x_o           (x_value_o),
    .f_o           (f_value_o),
    .flat_o        (stopped_flat_o),
    .last_o        (last_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("request not taken");
  a_strobe_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy_o)) else $error("result without request");
  a_final_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |=> !result_strobe_o) else $error("result after final");
  a_final_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |-> report_kind_o && f_value_o == '0)
    else $error("final result malformed");
endmodule
`default_nettype wire
